/* sv/ptc_lut_pkg.sv */
// package: formats, breakpoint rom and shared constants of the ptc lut interpolator
`default_nettype none

package ptc_lut_pkg;

   localparam int TABLE_POINTS   = 24;
   localparam int RES_FRAC_BITS  = 4;
   localparam int TEMP_FRAC_BITS = 8;

   localparam int RES_W  = 16;
   localparam int TEMP_W = 18;
   localparam int SEG_W  = $clog2(TABLE_POINTS);

   // widest segment span and step of the rom, in output formats
   localparam int DR_W   = 11;
   localparam int DT_W   = 12;
   localparam int PROD_W = DT_W + DR_W;
   localparam int CNT_W  = $clog2(DT_W);

   localparam int FB_MUL_W  = 11;
   localparam int FB_PROD_W = RES_W + FB_MUL_W;
   localparam int FB_SHIFT  = 10;
   localparam logic [FB_MUL_W-1:0]      FB_MUL    = 11'd1933;
   localparam logic signed [TEMP_W-1:0] FB_OFFSET = 18'sd25508;

   typedef logic [RES_W-1:0]         res_type;
   typedef logic signed [TEMP_W-1:0] temp_type;
   typedef logic [SEG_W-1:0]         seg_type;

   function automatic int rom_ohms(input seg_type k);
      int v;
      case (k)
         5'd0:    v = 490;
         5'd1:    v = 515;
         5'd2:    v = 567;
         5'd3:    v = 624;
         5'd4:    v = 684;
         5'd5:    v = 747;
         5'd6:    v = 815;
         5'd7:    v = 886;
         5'd8:    v = 961;
         5'd9:    v = 1000;
         5'd10:   v = 1040;
         5'd11:   v = 1122;
         5'd12:   v = 1209;
         5'd13:   v = 1299;
         5'd14:   v = 1392;
         5'd15:   v = 1490;
         5'd16:   v = 1591;
         5'd17:   v = 1696;
         5'd18:   v = 1805;
         5'd19:   v = 1915;
         5'd20:   v = 1970;
         5'd21:   v = 2023;
         5'd22:   v = 2124;
         5'd23:   v = 2211;
         default: v = 0;
      endcase
      return v;
   endfunction

   function automatic int rom_degc(input seg_type k);
      int v;
      case (k)
         5'd0:    v = -55;
         5'd1:    v = -50;
         5'd2:    v = -40;
         5'd3:    v = -30;
         5'd4:    v = -20;
         5'd5:    v = -10;
         5'd6:    v = 0;
         5'd7:    v = 10;
         5'd8:    v = 20;
         5'd9:    v = 25;
         5'd10:   v = 30;
         5'd11:   v = 40;
         5'd12:   v = 50;
         5'd13:   v = 60;
         5'd14:   v = 70;
         5'd15:   v = 80;
         5'd16:   v = 90;
         5'd17:   v = 100;
         5'd18:   v = 110;
         5'd19:   v = 120;
         5'd20:   v = 125;
         5'd21:   v = 130;
         5'd22:   v = 140;
         5'd23:   v = 150;
         default: v = 0;
      endcase
      return v;
   endfunction

   function automatic res_type res_point(input seg_type k);
      return RES_W'(rom_ohms(k) << RES_FRAC_BITS);
   endfunction

   function automatic temp_type temp_point(input seg_type k);
      return TEMP_W'(rom_degc(k) * (1 << TEMP_FRAC_BITS));
   endfunction

   localparam seg_type LAST_SEG = SEG_W'(TABLE_POINTS - 2);
   localparam seg_type LAST_PT  = SEG_W'(TABLE_POINTS - 1);

endpackage

`default_nettype wire

/* sv/ptc_lut_interpolator_core.sv */
// top level: ptc resistance to temperature converter with serial table search and divider
//
// usage
//   input word: req_resistance_q4 (ohms, unsigned q4), taken when req_valid is high and
//   req_stall is low. req_stall stays high while a word is being converted.
//   result word: rsp_temp_q8 (degrees c, signed q8) and rsp_in_range, shown when
//   rsp_valid is high and taken when rsp_stall is low.
//   for a word outside the table the sequencer goes straight to loading the result
//   register. for a word inside the table it runs the serial compare over the segments
//   (k being the segment it falls in, 0..22), a multiply step, the restoring divider
//   and then loads the result register, which raises rsp_valid.
//   a new word is not accepted while one is being converted; the next word is accepted
//   in the cycle after the result register is loaded, even while that result waits.
//   if the receiver stalls, the result register holds its word and a finished
//   conversion waits in its last step until the register is free.
//   reset clears the sequencer and rsp_valid; no word is in flight after it.
//
`default_nettype none

module ptc_lut_interpolator_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire ptc_lut_pkg::res_type     req_resistance_q4,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      ptc_lut_pkg::temp_type    rsp_temp_q8,
   output      logic                     rsp_in_range
);
   import ptc_lut_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_MULT   = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   res_type               r_ff, r_in;
   seg_type               seg_ff, seg_in;
   logic                  fb_ff, fb_in;
   logic [DR_W-1:0]       dr_ff, dr_in;
   logic [DR_W-1:0]       dres_ff, dres_in;
   logic [DT_W-1:0]       dt_ff, dt_in;
   temp_type              t0_ff, t0_in;
   logic                  dr_zero_ff, dr_zero_in;
   logic [DR_W-1:0]       rem_ff, rem_in;
   logic [DT_W-1:0]       quot_ff, quot_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   temp_type              rsp_temp_ff, rsp_temp_in;
   logic                  rsp_in_range_ff, rsp_in_range_in;

   logic                  req_fire;
   logic                  out_free;
   res_type               r0, r1;
   temp_type              t1;
   logic [PROD_W-1:0]     prod;
   logic [DR_W:0]         trial;
   logic [DR_W:0]         trial_diff;
   logic                  ge;
   logic [FB_PROD_W-1:0]  fb_prod;
   temp_type              fb_temp;
   temp_type              lut_temp;
   res_type               seg_r1;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign r0     = res_point(seg_ff);
   assign r1     = res_point(seg_ff + SEG_W'(1));
   assign t1     = temp_point(seg_ff + SEG_W'(1));
   assign seg_r1 = r1;

   assign prod       = PROD_W'(dt_ff) * PROD_W'(dres_ff);
   assign trial      = {rem_ff, quot_ff[DT_W-1]};
   assign trial_diff = trial - {1'b0, dr_ff};
   assign ge         = (trial >= {1'b0, dr_ff});

   assign fb_prod  = FB_PROD_W'(r_ff) * FB_PROD_W'(FB_MUL);
   assign fb_temp  = $signed({1'b0, fb_prod[FB_PROD_W-1:FB_SHIFT]}) - FB_OFFSET;
   assign lut_temp = dr_zero_ff ? t0_ff : t0_ff + $signed({{(TEMP_W-DT_W){1'b0}}, quot_ff});

   always_comb begin
      state_in        = state_ff;
      r_in            = r_ff;
      seg_in          = seg_ff;
      fb_in           = fb_ff;
      dr_in           = dr_ff;
      dres_in         = dres_ff;
      dt_in           = dt_ff;
      t0_in           = t0_ff;
      dr_zero_in      = dr_zero_ff;
      rem_in          = rem_ff;
      quot_in         = quot_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_temp_in     = rsp_temp_ff;
      rsp_in_range_in = rsp_in_range_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               r_in   = req_resistance_q4;
               seg_in = '0;
               if (req_resistance_q4 < res_point('0) ||
                   req_resistance_q4 > res_point(LAST_PT)) begin
                  fb_in    = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  fb_in    = 1'b0;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (r_ff <= seg_r1 || seg_ff == LAST_SEG) begin
               dr_in      = DR_W'(r1 - r0);
               dres_in    = DR_W'(r_ff - r0);
               dt_in      = DT_W'(t1 - temp_point(seg_ff));
               t0_in      = temp_point(seg_ff);
               dr_zero_in = (r1 == r0);
               state_in   = ST_MULT;
            end else begin
               seg_in = seg_ff + SEG_W'(1);
            end
         end
         ST_MULT: begin
            rem_in   = prod[PROD_W-1:DT_W];
            quot_in  = prod[DT_W-1:0];
            cnt_in   = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            rem_in  = ge ? trial_diff[DR_W-1:0] : trial[DR_W-1:0];
            quot_in = {quot_ff[DT_W-2:0], ge};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DT_W - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_temp_in     = fb_ff ? fb_temp : lut_temp;
               rsp_in_range_in = !fb_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff            <= r_in;
      seg_ff          <= seg_in;
      fb_ff           <= fb_in;
      dr_ff           <= dr_in;
      dres_ff         <= dres_in;
      dt_ff           <= dt_in;
      t0_ff           <= t0_in;
      dr_zero_ff      <= dr_zero_in;
      rem_ff          <= rem_in;
      quot_ff         <= quot_in;
      cnt_ff          <= cnt_in;
      rsp_temp_ff     <= rsp_temp_in;
      rsp_in_range_ff <= rsp_in_range_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_temp_q8  = rsp_temp_ff;
   assign rsp_in_range = rsp_in_range_ff;

   // search never passes a breakpoint above the sample
   a_search_below: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> r_ff >= r0)
      else $error("search passed the sample");

   // an accepted word always starts the sequencer
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("accepted word not started");

   // interpolated step never exceeds the segment's temperature step
   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !fb_ff && !dr_zero_ff) |-> quot_ff <= dt_ff)
      else $error("quotient above segment step");

   // a waiting result is never overwritten by the next conversion
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(rsp_temp_ff) && $stable(rsp_in_range_ff))
      else $error("waiting result overwritten");

endmodule

`default_nettype wire
